// File: sv/pauli_rotation_amplitude_update_unit_defines.svh
// Assertion macros for the Pauli rotation amplitude update unit.
// Used by the checker; needs nothing else.
`ifndef PAULI_ROTATION_AMPLITUDE_UPDATE_UNIT_DEFINES_SVH
`define PAULI_ROTATION_AMPLITUDE_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define PRAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, off while reset is held
`define PRAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, always active
`define PRAU_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: sv/prau_pkg.sv
// Shared types, constants and helpers of the Pauli rotation amplitude update unit.
// No dependencies.
package prau_pkg;

    localparam int NUM_QUBITS = 20;
    localparam int AMP_W      = 32;
    localparam int FRAC_BITS  = AMP_W - 2;
    localparam int ROT_W      = AMP_W + 1;          // negated partner part
    localparam int PROD_W     = AMP_W + ROT_W;      // widest product
    localparam int SUM_W      = PROD_W + 1;
    localparam int SHR_W      = SUM_W - FRAC_BITS;
    localparam int NUM_STAGES = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int POP_GRP    = 4;
    localparam int POP_NGRP   = (NUM_QUBITS + POP_GRP - 1) / POP_GRP;

    typedef logic [NUM_QUBITS-1:0]   t_idx;
    typedef logic signed [AMP_W-1:0] t_amp;
    typedef logic signed [ROT_W-1:0] t_rot;
    typedef logic signed [PROD_W-1:0] t_prod;

    localparam t_amp AMP_ONE = {2'b01, {FRAC_BITS{1'b0}}};
    localparam t_amp AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam t_amp AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MASK   = 3'd0,
        CFG_Z_MASK   = 3'd1,
        CFG_COS_HALF = 3'd2,
        CFG_SIN_HALF = 3'd3,
        CFG_COEF_RE  = 3'd4,
        CFG_COEF_IM  = 3'd5
    } t_cfg_reg;

    // partner phase factor after the i: i, 1, -i, -1
    typedef enum logic [1:0] {
        Q_POS_I   = 2'd0,
        Q_ONE     = 2'd1,
        Q_NEG_I   = 2'd2,
        Q_NEG_ONE = 2'd3
    } t_quarter;

    typedef struct packed {
        t_rot re;
        t_rot im;
    } t_rot_cplx;

    typedef struct packed {
        t_amp value;
        logic sat;
    } t_rs;

    // popcount mod 4, counted per nibble and then summed
    function automatic logic [1:0] pop_mod4(t_idx v);
        logic [2:0] grp;
        logic [1:0] total;
        total = '0;
        for (int g = 0; g < POP_NGRP; g++) begin
            grp = '0;
            for (int j = 0; j < POP_GRP; j++) begin
                if (g * POP_GRP + j < NUM_QUBITS) begin
                    grp = grp + {2'b00, v[g * POP_GRP + j]};
                end
            end
            total = total + grp[1:0];
        end
        return total;
    endfunction

endpackage

// File: sv/prau_if.sv
// Stream interfaces of the Pauli rotation amplitude update unit: input and result beats.
// Depends on prau_pkg.
interface prau_in_if;
    import prau_pkg::*;
    logic valid;
    logic ready;
    t_idx basis_index;
    t_amp amp_re;
    t_amp amp_im;
    t_amp partner_re;
    t_amp partner_im;

    modport source (output valid, basis_index, amp_re, amp_im, partner_re, partner_im,
                    input ready);
    modport sink   (input valid, basis_index, amp_re, amp_im, partner_re, partner_im,
                    output ready);
endinterface

interface prau_out_if;
    import prau_pkg::*;
    logic valid;
    logic ready;
    t_idx out_index;
    t_amp new_re;
    t_amp new_im;
    logic saturated;

    modport source (output valid, out_index, new_re, new_im, saturated, input ready);
    modport sink   (input valid, out_index, new_re, new_im, saturated, output ready);
endinterface

// File: sv/prau_phase_rot.sv
// Phase selection and partner rotation: i * (-i)^k * partner.
// Depends on prau_pkg.
module prau_phase_rot (
    input  prau_pkg::t_idx      i_x_mask,
    input  prau_pkg::t_idx      i_z_mask,
    input  prau_pkg::t_idx      i_idx,
    input  prau_pkg::t_amp      i_partner_re,
    input  prau_pkg::t_amp      i_partner_im,
    output prau_pkg::t_rot_cplx o_rot
);
    import prau_pkg::*;

    t_quarter w_k;
    t_rot     w_pr;
    t_rot     w_pi;

    assign w_pr = t_rot'(i_partner_re);
    assign w_pi = t_rot'(i_partner_im);
    assign w_k  = t_quarter'(pop_mod4(i_x_mask & i_z_mask) + {^(i_idx & i_z_mask), 1'b0});

    always_comb begin
        case (w_k)
            Q_POS_I: begin
                o_rot.re = -w_pi;
                o_rot.im = w_pr;
            end
            Q_ONE: begin
                o_rot.re = w_pr;
                o_rot.im = w_pi;
            end
            Q_NEG_I: begin
                o_rot.re = w_pi;
                o_rot.im = -w_pr;
            end
            Q_NEG_ONE: begin
                o_rot.re = -w_pr;
                o_rot.im = -w_pi;
            end
            default: begin
                o_rot.re = '0;
                o_rot.im = '0;
            end
        endcase
    end
endmodule

// File: sv/prau_round_sat.sv
// Sum or difference of two products, round half up to Q2.30, saturate.
// Depends on prau_pkg.
module prau_round_sat (
    input  prau_pkg::t_prod i_p1,
    input  prau_pkg::t_prod i_p2,
    input  logic            i_sub,
    output prau_pkg::t_rs   o_res
);
    import prau_pkg::*;

    logic signed [SUM_W-1:0] w_a;
    logic signed [SUM_W-1:0] w_b;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SHR_W-1:0] w_sh;
    logic                    w_ovf;

    assign w_a = SUM_W'(i_p1);
    // subtract as add of the complement, carry in through i_sub
    assign w_b = i_sub ? ~SUM_W'(i_p2) : SUM_W'(i_p2);
    assign w_sum = w_a + w_b + {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}}
                 + {{(SUM_W-1){1'b0}}, i_sub};
    assign w_sh  = w_sum[SUM_W-1:FRAC_BITS];
    assign w_ovf = !((&w_sh[SHR_W-1:AMP_W-1]) || !(|w_sh[SHR_W-1:AMP_W-1]));

    always_comb begin
        o_res.sat = w_ovf;
        if (w_ovf) begin
            o_res.value = w_sh[SHR_W-1] ? AMP_MIN : AMP_MAX;
        end else begin
            o_res.value = w_sh[AMP_W-1:0];
        end
    end
endmodule

// File: sv/pauli_rotation_amplitude_update_unit.sv
// Top level of the Pauli rotation amplitude update unit: config registers and 5-stage pipe.
// Depends on prau_pkg, prau_if, prau_phase_rot, prau_round_sat.
//
// Usage:
//   i_in  carries one amplitude beat: basis index, amplitude, and the partner
//         amplitude at index ^ x_mask (for a diagonal string, the amplitude itself).
//   o_out returns one beat per input beat, in order: echoed index, the updated
//         amplitude coef * (cos*amp + i*sin*(-i)^k*partner) in Q2.30, and a
//         saturated flag if either rounding step clipped.
//   Config: i_cfg_we / i_cfg_idx / i_cfg_wdata write x_mask, z_mask, cos_half,
//         sin_half, coef_re, coef_im (index 0..5); other indexes are ignored.
//         Write only while no beat is in flight.
// Timing:
//   Five register stages: rotate, multiply, round, multiply, round. A beat shows on
//   o_out from the last stage. Throughput is one beat per cycle while o_out.ready
//   holds; the 32x32 and 32x33 multipliers in stages two and four set the clock.
// Reset: synchronous, active low; empties the pipe and loads the register
//   defaults (identity rotation, coefficient 1.0).
// Stall: each stage holds while its successor is full and stalled; empty stages
//   still fill, so up to five beats sit in the pipe before i_in.ready drops.
module pauli_rotation_amplitude_update_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [prau_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prau_pkg::AMP_W-1:0]      i_cfg_wdata,
    prau_in_if.sink                         i_in,
    prau_out_if.source                      o_out
);
    import prau_pkg::*;

    // configuration
    t_idx r_x_mask;
    t_idx r_z_mask;
    t_amp r_cos;
    t_amp r_sin;
    t_amp r_coef_re;
    t_amp r_coef_im;

    // pipe control
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] w_rdy;
    t_idx                  r_idx [NUM_STAGES];

    // stage 0: amplitude and rotated partner
    t_rot_cplx w_rot;
    t_amp      r0_ar;
    t_amp      r0_ai;
    t_rot_cplx r0_rot;

    // stage 1: first products
    logic signed [2*AMP_W-1:0] w_car;
    logic signed [2*AMP_W-1:0] w_cai;
    logic signed [PROD_W-1:0]  w_srr;
    logic signed [PROD_W-1:0]  w_sri;
    t_prod r1_car;
    t_prod r1_cai;
    t_prod r1_srr;
    t_prod r1_sri;

    // stage 2: inner amplitude
    t_rs  w_ir;
    t_rs  w_ii;
    t_amp r2_ir;
    t_amp r2_ii;
    logic r2_sat;

    // stage 3: coefficient products
    logic signed [2*AMP_W-1:0] w_crir;
    logic signed [2*AMP_W-1:0] w_ciii;
    logic signed [2*AMP_W-1:0] w_crii;
    logic signed [2*AMP_W-1:0] w_ciir;
    t_prod r3_crir;
    t_prod r3_ciii;
    t_prod r3_crii;
    t_prod r3_ciir;
    logic  r3_sat;

    // stage 4: result register
    t_rs  w_nr;
    t_rs  w_ni;
    t_amp r4_nr;
    t_amp r4_ni;
    logic r4_sat;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_mask  <= '0;
            r_z_mask  <= '0;
            r_cos     <= AMP_ONE;
            r_sin     <= '0;
            r_coef_re <= AMP_ONE;
            r_coef_im <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_X_MASK:   r_x_mask  <= i_cfg_wdata[NUM_QUBITS-1:0];
                CFG_Z_MASK:   r_z_mask  <= i_cfg_wdata[NUM_QUBITS-1:0];
                CFG_COS_HALF: r_cos     <= i_cfg_wdata;
                CFG_SIN_HALF: r_sin     <= i_cfg_wdata;
                CFG_COEF_RE:  r_coef_re <= i_cfg_wdata;
                CFG_COEF_IM:  r_coef_im <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    // A stage loads when it is empty or its successor moves on.
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_out.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
    end

    always_comb begin
        n_v[0] = w_rdy[0] ? i_in.valid : r_v[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            n_v[i] = w_rdy[i] ? r_v[i-1] : r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_idx[0] <= i_in.basis_index;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (w_rdy[i]) begin
                r_idx[i] <= r_idx[i-1];
            end
        end
    end

    assign i_in.ready = w_rdy[0];

    // ---------------- stage 0: phase and rotation ----------------
    prau_phase_rot u_rot (
        .i_x_mask     (r_x_mask),
        .i_z_mask     (r_z_mask),
        .i_idx        (i_in.basis_index),
        .i_partner_re (i_in.partner_re),
        .i_partner_im (i_in.partner_im),
        .o_rot        (w_rot)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_ar  <= i_in.amp_re;
            r0_ai  <= i_in.amp_im;
            r0_rot <= w_rot;
        end
    end

    // ---------------- stage 1: cos*amp, sin*rot ----------------
    assign w_car = r_cos * r0_ar;
    assign w_cai = r_cos * r0_ai;
    assign w_srr = r_sin * r0_rot.re;
    assign w_sri = r_sin * r0_rot.im;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_car <= t_prod'(w_car);
            r1_cai <= t_prod'(w_cai);
            r1_srr <= w_srr;
            r1_sri <= w_sri;
        end
    end

    // ---------------- stage 2: round inner amplitude ----------------
    prau_round_sat u_rs_ir (
        .i_p1  (r1_car),
        .i_p2  (r1_srr),
        .i_sub (1'b0),
        .o_res (w_ir)
    );

    prau_round_sat u_rs_ii (
        .i_p1  (r1_cai),
        .i_p2  (r1_sri),
        .i_sub (1'b0),
        .o_res (w_ii)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_ir  <= w_ir.value;
            r2_ii  <= w_ii.value;
            r2_sat <= w_ir.sat | w_ii.sat;
        end
    end

    // ---------------- stage 3: coefficient products ----------------
    assign w_crir = r_coef_re * r2_ir;
    assign w_ciii = r_coef_im * r2_ii;
    assign w_crii = r_coef_re * r2_ii;
    assign w_ciir = r_coef_im * r2_ir;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_crir <= t_prod'(w_crir);
            r3_ciii <= t_prod'(w_ciii);
            r3_crii <= t_prod'(w_crii);
            r3_ciir <= t_prod'(w_ciir);
            r3_sat  <= r2_sat;
        end
    end

    // ---------------- stage 4: round result ----------------
    // re = cr*ir - ci*ii, im = cr*ii + ci*ir
    prau_round_sat u_rs_nr (
        .i_p1  (r3_crir),
        .i_p2  (r3_ciii),
        .i_sub (1'b1),
        .o_res (w_nr)
    );

    prau_round_sat u_rs_ni (
        .i_p1  (r3_crii),
        .i_p2  (r3_ciir),
        .i_sub (1'b0),
        .o_res (w_ni)
    );

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_nr  <= w_nr.value;
            r4_ni  <= w_ni.value;
            r4_sat <= r3_sat | w_nr.sat | w_ni.sat;
        end
    end

    assign o_out.valid     = r_v[NUM_STAGES-1];
    assign o_out.out_index = r_idx[NUM_STAGES-1];
    assign o_out.new_re    = r4_nr;
    assign o_out.new_im    = r4_ni;
    assign o_out.saturated = r4_sat;

endmodule

// File: sv/prau_checker.sv
// Port-level checks for the Pauli rotation amplitude update unit, bound to the top level.
// Depends on prau_pkg and pauli_rotation_amplitude_update_unit_defines.svh.
`include "pauli_rotation_amplitude_update_unit_defines.svh"

module prau_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input prau_pkg::t_idx  i_out_index,
    input prau_pkg::t_amp  i_new_re,
    input prau_pkg::t_amp  i_new_im,
    input logic            i_saturated
);
    import prau_pkg::*;

    logic                              w_stall;
    logic [NUM_QUBITS+2*AMP_W:0]       w_payload;

    assign w_stall   = i_out_valid && !i_out_ready;
    assign w_payload = {i_out_index, i_new_re, i_new_im, i_saturated};

    // a stalled result beat stays up
    `PRAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid)

    // and keeps its payload
    `PRAU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable(w_payload))

    // a ready sink lets the whole pipe advance
    `PRAU_ASSERT_NOW(a_ready_flow, i_clk, i_rst_n, i_out_ready, i_in_ready)

    // reset flushes the pipe
    `PRAU_ASSERT_NEXT_ANY(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind pauli_rotation_amplitude_update_unit prau_checker u_prau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_index (o_out.out_index),
    .i_new_re    (o_out.new_re),
    .i_new_im    (o_out.new_im),
    .i_saturated (o_out.saturated)
);
